// ----- rtl/mfr_pkg.sv -----
// shared types and constants for the matrix flip and rotate engine
// no dependencies
`timescale 1ns / 1ps
package mfr_pkg;
    localparam int MaxDim    = 128;
    localparam int DataWidth = 32;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_XFORM = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] ST_READ   = 2'd0;
    localparam logic [1:0] ST_DONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [2:0] OP_FLIP_UD = 3'd1;
    localparam logic [2:0] OP_FLIP_LR = 3'd2;
    localparam logic [2:0] OP_ROT_CW  = 3'd3;
    localparam logic [2:0] OP_ROT_CCW = 3'd4;
    localparam logic [2:0] OP_QUAD_CW = 3'd5;
    localparam logic [2:0] OP_QUAD_CCW = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic signed [31:0] value;
        logic [2:0]  op;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] elem_value;
        logic [6:0]  row_index;
        logic [6:0]  col_index;
        logic        last;
        logic [1:0]  status;
    } out_item_t;
endpackage

// ----- rtl/mfr_front.sv -----
// front end: takes command words into a two-entry queue
// depends on mfr_pkg
`timescale 1ns / 1ps
module mfr_front
    import mfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  in_item_t item,
    output logic     full,
    input  logic     pop,
    output logic     avail,
    output in_item_t head
);
    in_item_t q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign full  = cnt_reg == 2'd2;
    assign push  = start && !full && item.kind != KIND_NOP;
    assign avail = cnt_reg != 2'd0;
    assign head  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !(push && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("queue underflow");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count");
endmodule

// ----- rtl/mfr_back.sv -----
// back end: matrix memory, load/read pointers and the transform sequencer
// depends on mfr_pkg
`timescale 1ns / 1ps
module mfr_back
    import mfr_pkg::*;
#(
    parameter int MAX_DIM    = MaxDim,
    parameter int DATA_WIDTH = DataWidth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  in_item_t    head,
    output logic        pop,
    input  logic [7:0]  row_cfg,
    input  logic [7:0]  col_cfg,
    output logic        strobe,
    output out_item_t   result
);
    localparam int DW = $clog2(MAX_DIM);
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int AW = 2 * DW;
    localparam int PW = $clog2(MAX_DIM * MAX_DIM + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_COPY  = 3'd2;
    localparam logic [2:0] S_RDOUT = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;

    logic [DATA_WIDTH-1:0] mat_mem [MAX_DIM*MAX_DIM];
    logic [DATA_WIDTH-1:0] scr_mem [MAX_DIM*MAX_DIM];

    logic [2:0]    st_reg, st_next;
    logic [CW-1:0] rows_reg, cols_reg, rows_next, cols_next;
    logic [DW-1:0] lr_reg, lc_reg, lr_next, lc_next;
    logic          lp_zero_reg, lp_zero_next;
    logic [DW-1:0] rr_reg, rc_reg, rr_next, rc_next;
    logic [DW-1:0] a_reg, b_reg, a_next, b_next;
    logic [2:0]    op_reg, op_next;
    logic          pend_reg, pend_next;
    logic [DW-1:0] pr_reg, pc_reg;
    logic          plast_reg, pend_strobe_reg;
    logic [DATA_WIDTH-1:0] mrd_reg, srd_reg;
    logic          cp_v_reg;
    logic [AW-1:0] cp_a_reg;
    logic          strobe_reg, strobe_next;
    out_item_t     res_reg, res_next;

    logic          mat_we, scr_we;
    logic [AW-1:0] mat_wa, mat_ra, scr_wa, scr_ra;
    logic [DATA_WIDTH-1:0] mat_wd;
    logic [DW-1:0] dr, dc;
    logic [CW-1:0] ld_rows, ld_cols, hr, hc;
    logic          top, left;
    logic [2:0]    opn;

    function automatic logic [CW-1:0] clampd(input logic [7:0] v);
        logic [CW-1:0] r;
        if (v < 8'd2)
            r = CW'(2);
        else if (32'(v) > MAX_DIM)
            r = CW'(MAX_DIM);
        else
            r = CW'(v);
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (mat_we)
            mat_mem[mat_wa] <= mat_wd;
        mrd_reg <= mat_mem[mat_ra];
        if (scr_we)
            scr_mem[scr_wa] <= mrd_reg;
        srd_reg <= scr_mem[scr_ra];
    end

    assign hr = rows_reg >> 1;
    assign hc = cols_reg >> 1;
    assign top  = CW'(a_reg) < hr;
    assign left = CW'(b_reg) < hc;
    assign ld_rows = lp_zero_reg ? clampd(row_cfg) : rows_reg;
    assign ld_cols = lp_zero_reg ? clampd(col_cfg) : cols_reg;

    // destination of the source element at (a, b)
    always_comb
    begin
        dr = a_reg;
        dc = b_reg;
        case (op_reg)
            OP_FLIP_UD: dr = DW'(rows_reg - 1'b1 - CW'(a_reg));
            OP_FLIP_LR: dc = DW'(cols_reg - 1'b1 - CW'(b_reg));
            OP_ROT_CW:
            begin
                dr = b_reg;
                dc = DW'(rows_reg - 1'b1 - CW'(a_reg));
            end
            OP_ROT_CCW:
            begin
                dr = DW'(cols_reg - 1'b1 - CW'(b_reg));
                dc = a_reg;
            end
            OP_QUAD_CW:
            begin
                if (top && left) dc = DW'(CW'(b_reg) + hc);
                else if (top) dr = DW'(CW'(a_reg) + hr);
                else if (!left) dc = DW'(CW'(b_reg) - hc);
                else dr = DW'(CW'(a_reg) - hr);
            end
            default:
            begin
                if (top && left) dr = DW'(CW'(a_reg) + hr);
                else if (!top && left) dc = DW'(CW'(b_reg) + hc);
                else if (!top) dr = DW'(CW'(a_reg) - hr);
                else dc = DW'(CW'(b_reg) - hc);
            end
        endcase
    end

    always_comb
    begin
        opn = (head.op >= 3'd1 && head.op <= 3'd5) ? head.op : OP_QUAD_CCW;
        st_next = st_reg;
        rows_next = rows_reg;
        cols_next = cols_reg;
        lr_next = lr_reg;
        lc_next = lc_reg;
        lp_zero_next = lp_zero_reg;
        rr_next = rr_reg;
        rc_next = rc_reg;
        a_next = a_reg;
        b_next = b_reg;
        op_next = op_reg;
        pend_next = 1'b0;
        strobe_next = 1'b0;
        res_next = '0;
        pop = 1'b0;
        mat_we = 1'b0;
        mat_wa = {lr_reg, lc_reg};
        mat_wd = DATA_WIDTH'(head.value);
        mat_ra = {a_reg, b_reg};
        scr_we = cp_v_reg;
        scr_wa = cp_a_reg;
        scr_ra = {a_reg, b_reg};
        case (st_reg)
            S_IDLE:
            begin
                if (avail)
                begin
                    pop = 1'b1;
                    case (head.kind)
                        KIND_LOAD:
                        begin
                            rows_next = ld_rows;
                            cols_next = ld_cols;
                            mat_we = 1'b1;
                            mat_wa = lp_zero_reg ? '0 : {lr_reg, lc_reg};
                            rr_next = '0;
                            rc_next = '0;
                            if (lp_zero_reg)
                            begin
                                lr_next = '0;
                                lc_next = '0;
                            end
                            if (CW'(lp_zero_reg ? '0 : lc_reg) + 1'b1 >= ld_cols)
                            begin
                                lc_next = '0;
                                if (CW'(lp_zero_reg ? '0 : lr_reg) + 1'b1 >= ld_rows)
                                begin
                                    lr_next = '0;
                                    lp_zero_next = 1'b1;
                                end
                                else
                                begin
                                    lr_next = (lp_zero_reg ? '0 : lr_reg) + 1'b1;
                                    lp_zero_next = 1'b0;
                                end
                            end
                            else
                            begin
                                lc_next = (lp_zero_reg ? '0 : lc_reg) + 1'b1;
                                lp_zero_next = 1'b0;
                            end
                        end
                        KIND_XFORM:
                        begin
                            lp_zero_next = 1'b1;
                            lr_next = '0;
                            lc_next = '0;
                            rr_next = '0;
                            rc_next = '0;
                            op_next = opn;
                            a_next = '0;
                            b_next = '0;
                            if (rows_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                res_next.status = ST_DONE;
                            end
                            else if (opn >= OP_QUAD_CW && (rows_reg[0] || cols_reg[0]))
                            begin
                                strobe_next = 1'b1;
                                res_next.status = ST_REJECT;
                            end
                            else
                                st_next = S_WALK;
                        end
                        default:
                        begin
                            if (rows_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                res_next.last = 1'b1;
                            end
                            else
                            begin
                                mat_ra = {rr_reg, rc_reg};
                                pend_next = 1'b1;
                                if (CW'(rc_reg) + 1'b1 >= cols_reg)
                                begin
                                    rc_next = '0;
                                    rr_next = (CW'(rr_reg) + 1'b1 >= rows_reg) ? '0 : rr_reg + 1'b1;
                                end
                                else
                                    rc_next = rc_reg + 1'b1;
                                st_next = S_RDOUT;
                            end
                        end
                    endcase
                end
            end
            S_RDOUT:
                st_next = S_IDLE;
            S_WALK:
            begin
                if (CW'(b_reg) + 1'b1 >= cols_reg)
                begin
                    b_next = '0;
                    if (CW'(a_reg) + 1'b1 >= rows_reg)
                    begin
                        a_next = '0;
                        st_next = S_WAIT;
                        if (op_reg == OP_ROT_CW || op_reg == OP_ROT_CCW)
                        begin
                            rows_next = cols_reg;
                            cols_next = rows_reg;
                        end
                    end
                    else
                        a_next = a_reg + 1'b1;
                end
                else
                    b_next = b_reg + 1'b1;
            end
            S_WAIT:
                st_next = S_COPY;
            S_COPY:
            begin
                if (pend_strobe_reg)
                begin
                    mat_we = 1'b1;
                    mat_wa = {pr_reg, pc_reg};
                    mat_wd = srd_reg;
                end
                if (CW'(b_reg) + 1'b1 >= cols_reg)
                begin
                    b_next = '0;
                    if (CW'(a_reg) + 1'b1 >= rows_reg)
                        a_next = '0;
                    else
                        a_next = a_reg + 1'b1;
                end
                else
                    b_next = b_reg + 1'b1;
                if (plast_reg)
                begin
                    st_next = S_IDLE;
                    strobe_next = 1'b1;
                    res_next.status = ST_DONE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
        if (pend_reg)
        begin
            strobe_next = 1'b1;
            res_next.elem_value = 32'(mrd_reg);
            res_next.row_index = 7'(pr_reg);
            res_next.col_index = 7'(pc_reg);
            res_next.last = plast_reg;
        end
    end

    // pr/pc/plast track the read in flight; in copy they hold a/b from the cycle before
    always_ff @(posedge clk)
    begin
        cp_v_reg <= (st_reg == S_WALK);
        cp_a_reg <= {dr, dc};
        if (st_reg == S_IDLE)
        begin
            pr_reg <= rr_reg;
            pc_reg <= rc_reg;
            plast_reg <= (CW'(rc_reg) + 1'b1 >= cols_reg) && (CW'(rr_reg) + 1'b1 >= rows_reg);
        end
        else if (st_reg == S_WAIT || st_reg == S_COPY)
        begin
            pr_reg <= a_reg;
            pc_reg <= b_reg;
            plast_reg <= (CW'(b_reg) + 1'b1 >= cols_reg) && (CW'(a_reg) + 1'b1 >= rows_reg);
        end
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            rows_reg <= '0;
            cols_reg <= '0;
            lr_reg <= '0;
            lc_reg <= '0;
            lp_zero_reg <= 1'b1;
            rr_reg <= '0;
            rc_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            op_reg <= OP_QUAD_CCW;
            pend_reg <= 1'b0;
            pend_strobe_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            rows_reg <= rows_next;
            cols_reg <= cols_next;
            lr_reg <= lr_next;
            lc_reg <= lc_next;
            lp_zero_reg <= lp_zero_next;
            rr_reg <= rr_next;
            rc_reg <= rc_next;
            a_reg <= a_next;
            b_reg <= b_next;
            op_reg <= op_next;
            pend_reg <= pend_next;
            pend_strobe_reg <= (st_reg == S_WAIT || st_reg == S_COPY);
            strobe_reg <= strobe_next;
        end
    end

    assign strobe = strobe_reg;
    assign result = res_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> st_reg == S_IDLE) else $error("pop outside idle");
    a_read_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> strobe_reg) else $error("read lost");
    a_size_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (rows_reg == '0) == (cols_reg == '0)) else $error("size mismatch");
endmodule

// ----- rtl/matrix_flip_rotate_engine.sv -----
// top level: apb config registers, command queue and transform back end
// depends on mfr_pkg, mfr_front, mfr_back
`timescale 1ns / 1ps
// A load is written from idle, a read passes through a readout state; a transform
// of an R by C matrix walks the matrix memory into scratch and back, each memory
// with a single write port. Busy is high while the two-word command queue is full.
// Each word gives at most one result, shown for one cycle on strobe; the receiver
// cannot hold it off. Memories need no clearing after reset.
module matrix_flip_rotate_engine
    import mfr_pkg::*;
#(
    parameter int MAX_DIM    = MaxDim,
    parameter int DATA_WIDTH = DataWidth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        strobe,
    output out_item_t   result
);
    logic [7:0] row_cfg_reg, col_cfg_reg;
    logic       avail, pop;
    in_item_t   head;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {24'd0, col_cfg_reg} : {24'd0, row_cfg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= 8'd8;
            col_cfg_reg <= 8'd8;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr == 3'd0)
                row_cfg_reg <= pwdata[7:0];
            else if (paddr == 3'd4)
                col_cfg_reg <= pwdata[7:0];
        end
    end

    mfr_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .full(busy),
        .pop(pop), .avail(avail), .head(head)
    );

    mfr_back #(.MAX_DIM(MAX_DIM), .DATA_WIDTH(DATA_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n), .avail(avail), .head(head), .pop(pop),
        .row_cfg(row_cfg_reg), .col_cfg(col_cfg_reg), .strobe(strobe), .result(result)
    );
endmodule

// ----- tb/sv/tb.sv -----
// testbench for matrix_flip_rotate_engine: directed and random command streams
// checked against an in-bench matrix predictor; depends on mfr_pkg and the rtl
`timescale 1ns / 1ps
module tb;
    import mfr_pkg::*;

    localparam int CELLS      = MaxDim * MaxDim;
    localparam int LIMIT      = 1500000;
    localparam logic [2:0] ADDR_ROWS = 3'd0;
    localparam logic [2:0] ADDR_COLS = 3'd4;
    localparam int DRAIN_WAIT = 24;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        strobe;
    out_item_t   result;

    // predictor state
    logic signed [31:0] mat_words [CELLS];
    logic signed [31:0] scratch_words [CELLS];
    bit                 word_known [CELLS];
    int unsigned        live_rows;
    int unsigned        live_cols;
    int unsigned        fill_ptr;
    int unsigned        scan_ptr;
    logic [7:0]         rows_reg;
    logic [7:0]         cols_reg;

    out_item_t   expected_q[$];
    out_item_t   exp_word;
    int          errors;
    int          sent_count;
    int unsigned cycles;
    bit          no_gaps;

    matrix_flip_rotate_engine dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int unsigned clamp_size(logic [7:0] v);
        if (v < 2)
            return 2;
        if (v > MaxDim)
            return MaxDim;
        return v;
    endfunction

    function automatic int unsigned cell_of(int unsigned r, int unsigned c);
        return (r * MaxDim + c) % CELLS;
    endfunction

    function automatic logic [1:0] apply_transform(logic [2:0] op_in);
        int unsigned rr;
        int unsigned cc;
        int unsigned hr;
        int unsigned hc;
        int unsigned nr;
        int unsigned nc;
        int unsigned dr;
        int unsigned dc;
        logic [2:0]  op;
        bit          top;
        bit          left;
        rr = live_rows;
        cc = live_cols;
        hr = rr / 2;
        hc = cc / 2;
        nr = rr;
        nc = cc;
        op = op_in;
        if (op < OP_FLIP_UD || op > OP_QUAD_CW)
            op = OP_QUAD_CCW;
        if (op >= OP_QUAD_CW && (rr[0] || cc[0]))
            return ST_REJECT;
        if (op == OP_ROT_CW || op == OP_ROT_CCW)
        begin
            nr = cc;
            nc = rr;
        end
        for (int a = 0; a < rr; a++)
        begin
            for (int b = 0; b < cc; b++)
            begin
                dr = a;
                dc = b;
                top = a < hr;
                left = b < hc;
                case (op)
                    OP_FLIP_UD: dr = rr - 1 - a;
                    OP_FLIP_LR: dc = cc - 1 - b;
                    OP_ROT_CW:
                    begin
                        dr = b;
                        dc = rr - 1 - a;
                    end
                    OP_ROT_CCW:
                    begin
                        dr = cc - 1 - b;
                        dc = a;
                    end
                    OP_QUAD_CW:
                    begin
                        if (top && left) dc = b + hc;
                        else if (top) dr = a + hr;
                        else if (!left) dc = b - hc;
                        else dr = a - hr;
                    end
                    default:
                    begin
                        if (top && left) dr = a + hr;
                        else if (!top && left) dc = b + hc;
                        else if (!top) dr = a - hr;
                        else dc = b - hc;
                    end
                endcase
                scratch_words[cell_of(dr, dc)] = mat_words[cell_of(a, b)];
            end
        end
        for (int a = 0; a < nr; a++)
        begin
            for (int b = 0; b < nc; b++)
            begin
                mat_words[cell_of(a, b)] = scratch_words[cell_of(a, b)];
                word_known[cell_of(a, b)] = 1'b1;
            end
        end
        live_rows = nr;
        live_cols = nc;
        return ST_DONE;
    endfunction

    // update the matrix model for one accepted word, queue its result if any
    function automatic void predict_word(in_item_t w);
        out_item_t   r;
        int unsigned total;
        r = '0;
        case (w.kind)
            KIND_LOAD:
            begin
                if (fill_ptr == 0)
                begin
                    live_rows = clamp_size(rows_reg);
                    live_cols = clamp_size(cols_reg);
                end
                total = live_rows * live_cols;
                if (fill_ptr >= total)
                    fill_ptr = 0;
                mat_words[cell_of(fill_ptr / live_cols, fill_ptr % live_cols)] = w.value;
                word_known[cell_of(fill_ptr / live_cols, fill_ptr % live_cols)] = 1'b1;
                fill_ptr++;
                if (fill_ptr >= total)
                    fill_ptr = 0;
                scan_ptr = 0;
            end
            KIND_XFORM:
            begin
                r.status = apply_transform(w.op);
                fill_ptr = 0;
                scan_ptr = 0;
                expected_q = {expected_q, r};
            end
            KIND_READ:
            begin
                total = live_rows * live_cols;
                r.status = ST_READ;
                if (total == 0)
                    r.last = 1'b1;
                else
                begin
                    if (scan_ptr >= total)
                        scan_ptr = 0;
                    r.elem_value = mat_words[cell_of(scan_ptr / live_cols, scan_ptr % live_cols)];
                    r.row_index = 7'(scan_ptr / live_cols);
                    r.col_index = 7'(scan_ptr % live_cols);
                    scan_ptr++;
                    if (scan_ptr >= total)
                    begin
                        r.last = 1'b1;
                        scan_ptr = 0;
                    end
                end
                expected_q = {expected_q, r};
            end
            default: ;
        endcase
    endfunction

    // a read must never hit an element that was never written
    function automatic bit read_is_safe();
        int unsigned total;
        int unsigned p;
        total = live_rows * live_cols;
        if (total == 0)
            return 1'b1;
        p = (scan_ptr >= total) ? 0 : scan_ptr;
        return word_known[cell_of(p / live_cols, p % live_cols)];
    endfunction

    function automatic bit transform_is_safe();
        for (int a = 0; a < live_rows; a++)
            for (int b = 0; b < live_cols; b++)
                if (!word_known[cell_of(a, b)])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic in_item_t make_word(logic [1:0] k, logic [31:0] v, logic [2:0] op);
        in_item_t w;
        w.kind = k;
        w.value = v;
        w.op = op;
        return w;
    endfunction

    task automatic send_word(in_item_t w);
        int gap;
        int pick;
        @(negedge clk);
        start <= 1'b1;
        item <= w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_word(w);
        sent_count++;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60)
            gap = 0;
        else if (pick < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // send a random value, swapping an unsafe read or transform for a load
    task automatic send_safe(logic [1:0] k, logic [2:0] op);
        logic [1:0] kk;
        kk = k;
        if (kk == KIND_READ && !read_is_safe())
            kk = KIND_LOAD;
        if (kk == KIND_XFORM && !transform_is_safe())
            kk = KIND_LOAD;
        send_word(make_word(kk, $urandom, op));
    endtask

    task automatic wait_empty();
        @(negedge clk);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        wait_empty();
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        if (addr == ADDR_ROWS)
            rows_reg = data[7:0];
        else
            cols_reg = data[7:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_size(logic [7:0] r, logic [7:0] c);
        write_reg(ADDR_ROWS, {8'($urandom_range(0, 255)), 16'h0, r});
        write_reg(ADDR_COLS, {8'($urandom_range(0, 255)), 16'h0, c});
    endtask

    task automatic load_full(int unsigned n);
        repeat (n) send_word(make_word(KIND_LOAD, $urandom, '0));
    endtask

    task automatic test_empty_matrix();
        send_word(make_word(KIND_READ, 32'h0, '0));
        send_word(make_word(KIND_XFORM, 32'h0, OP_ROT_CW));
        send_word(make_word(KIND_NOP, 32'hffff_ffff, 3'd7));
        send_word(make_word(KIND_READ, 32'h0, '0));
    endtask

    task automatic test_all_ops();
        set_size(8'd2, 8'd4);
        send_word(make_word(KIND_LOAD, 32'h8000_0000, '0));
        send_word(make_word(KIND_LOAD, 32'h7fff_ffff, '0));
        send_word(make_word(KIND_LOAD, 32'hffff_ffff, '0));
        send_word(make_word(KIND_LOAD, 32'h0000_0000, '0));
        load_full(4);
        for (int op = 0; op < 8; op++)
        begin
            send_word(make_word(KIND_XFORM, $urandom, 3'(op)));
            send_word(make_word(KIND_READ, $urandom, '0));
        end
        repeat (8) send_word(make_word(KIND_READ, 32'h0, '0));
    endtask

    // odd sizes reject the quadrant cycles and leave the matrix alone
    task automatic test_odd_quadrant();
        set_size(8'd3, 8'd4);
        load_full(12);
        send_word(make_word(KIND_XFORM, 32'h0, OP_QUAD_CW));
        send_word(make_word(KIND_XFORM, 32'h0, OP_QUAD_CCW));
        send_word(make_word(KIND_XFORM, 32'h0, 3'd0));
        send_word(make_word(KIND_XFORM, 32'h0, 3'd7));
        send_word(make_word(KIND_XFORM, 32'h0, OP_ROT_CCW));
        send_word(make_word(KIND_XFORM, 32'h0, OP_QUAD_CW));
        repeat (12) send_word(make_word(KIND_READ, 32'h0, '0));
    endtask

    // out of range sizes clamp; 128 rows reach the top row index
    task automatic test_size_clamp();
        set_size(8'd0, 8'd1);
        load_full(4);
        send_word(make_word(KIND_XFORM, 32'h0, OP_QUAD_CW));
        repeat (5) send_word(make_word(KIND_READ, 32'h0, '0));
        set_size(8'd255, 8'd2);
        load_full(3);
        repeat (3) send_word(make_word(KIND_READ, 32'h0, '0));
        load_full(256);
        send_word(make_word(KIND_XFORM, 32'h0, OP_FLIP_UD));
        repeat (256) send_word(make_word(KIND_READ, 32'h0, '0));
        set_size(8'd128, 8'd128);
        load_full(5);
        repeat (3) send_word(make_word(KIND_READ, 32'h0, '0));
    endtask

    task automatic test_random_stream(int target);
        int unsigned r;
        int unsigned c;
        int pick;
        while (sent_count < target)
        begin
            pick = $urandom_range(0, 9);
            r = (pick == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            c = (pick == 1) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            set_size(8'(r), 8'(c));
            no_gaps = ($urandom_range(0, 3) == 0);
            load_full(clamp_size(8'(r)) * clamp_size(8'(c)));
            repeat ($urandom_range(8, 20))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_safe(KIND_READ, '0);
                else if (pick < 75)
                    send_safe(KIND_XFORM, 3'($urandom_range(0, 7)));
                else if (pick < 92)
                    send_safe(KIND_LOAD, '0);
                else
                    send_word(make_word(KIND_NOP, $urandom, 3'($urandom_range(0, 7))));
            end
            if ($urandom_range(0, 2) == 0)
                repeat (live_rows * live_cols)
                    send_safe(KIND_READ, '0);
            if ($urandom_range(0, 4) == 0)
                wait_empty();
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        if (rst_n && strobe)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%t unexpected word: expected none, actual %p", $time, result);
            end
            else
            begin
                exp_word = expected_q.pop_front();
                if (result.elem_value !== exp_word.elem_value)
                begin
                    errors++;
                    $display("%t elem_value exp %0d act %0d", $time,
                             exp_word.elem_value, result.elem_value);
                end
                if (result.row_index !== exp_word.row_index)
                begin
                    errors++;
                    $display("%t row_index exp %0d act %0d", $time,
                             exp_word.row_index, result.row_index);
                end
                if (result.col_index !== exp_word.col_index)
                begin
                    errors++;
                    $display("%t col_index exp %0d act %0d", $time,
                             exp_word.col_index, result.col_index);
                end
                if (result.last !== exp_word.last)
                begin
                    errors++;
                    $display("%t last exp %0d act %0d", $time, exp_word.last, result.last);
                end
                if (result.status !== exp_word.status)
                begin
                    errors++;
                    $display("%t status exp %0d act %0d", $time,
                             exp_word.status, result.status);
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        item = '0;
        errors = 0;
        sent_count = 0;
        cycles = 0;
        no_gaps = 1'b0;
        live_rows = 0;
        live_cols = 0;
        fill_ptr = 0;
        scan_ptr = 0;
        rows_reg = 8'd8;
        cols_reg = 8'd8;
        for (int i = 0; i < CELLS; i++)
        begin
            mat_words[i] = '0;
            scratch_words[i] = '0;
            word_known[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_matrix();
        test_all_ops();
        test_odd_quadrant();
        test_size_clamp();
        test_random_stream(1350);

        wait_empty();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
